// ===== hw/rtl/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// asgr_pkg
// shared types, character codes and helpers for the sgr colour decoder
// ----------------------------------------------------------------------------
package asgr_pkg;

    localparam int VALUE_W = 14;

    typedef logic [7:0]         byte_t;
    typedef logic [3:0]         code_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [3:0]         fg_t;
    typedef logic [2:0]         bg_t;
    typedef logic [6:0]         attr_t;

    localparam byte_t ESC_BYTE      = 8'h1B;
    localparam byte_t CHAR_ZERO     = 8'h30;
    localparam byte_t CHAR_NINE     = 8'h39;
    localparam byte_t CHAR_SEMI     = 8'h3B;
    localparam byte_t CHAR_LBRACKET = 8'h5B;
    localparam byte_t CHAR_M        = 8'h6D;
    localparam byte_t FINAL_LO      = 8'h40;
    localparam byte_t FINAL_HI      = 8'h7E;

    localparam code_t CODE_SEMI  = 4'd10;
    localparam code_t CODE_DIGIT_MAX = 4'd9;

    localparam value_t VALUE_LIMIT = 14'd999;
    localparam value_t SGR_RESET   = 14'd0;
    localparam value_t SGR_BOLD    = 14'd1;
    localparam value_t SGR_FG_LO   = 14'd30;
    localparam value_t SGR_FG_HI   = 14'd37;
    localparam value_t SGR_BG_LO   = 14'd40;
    localparam value_t SGR_BG_HI   = 14'd47;
    localparam value_t SGR_BRT_LO  = 14'd90;
    localparam value_t SGR_BRT_HI  = 14'd97;
    localparam value_t BRT_OFFSET  = 14'd82;

    localparam fg_t FG_RESET = 4'hF;
    localparam bg_t BG_RESET = 3'd0;

    function automatic attr_t make_attribute(fg_t fg, bg_t bg, logic bold);
        logic bright;
        bright = fg[3] | bold;
        return {bg, bright, fg[2:0]};
    endfunction

endpackage

// ===== hw/rtl/asgr_ram.sv =====
// ----------------------------------------------------------------------------
// asgr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module asgr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/ansi_sgr_color_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_color_decoder_core
// strips ansi escape sequences and tags passed bytes with a vga attribute
// ----------------------------------------------------------------------------
// Each input beat carries one byte. Bytes outside escape sequences leave as
// one output beat with the current attribute (bg 6..4, intensity 3, fg 2..0);
// escape and csi bytes give no output. A new byte is taken while an earlier
// output still waits, except that a byte which itself produces output needs
// the output register free. The 'm' terminator of a csi sequence holds off
// input while one shared multiply-by-ten-and-add unit walks the parameter
// ram, one character per read and evaluate pair, because the ram returns
// registered read data; an oversized value ends the walk early.
// ----------------------------------------------------------------------------
module ansi_sgr_color_decoder_core #(
    parameter int MAX_PARAM_CHARS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [6:0] attribute
);

    localparam int CW = $clog2(MAX_PARAM_CHARS + 1);
    localparam int AW = (MAX_PARAM_CHARS > 1) ? $clog2(MAX_PARAM_CHARS) : 1;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI,
        MODE_DISCARD
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FETCH,
        SEQ_EVAL
    } seq_t;

    mode_t               mode_reg, mode_next;
    seq_t                seq_reg, seq_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    asgr_pkg::value_t    value_reg, value_next;
    asgr_pkg::fg_t       fg_reg, fg_next;
    asgr_pkg::bg_t       bg_reg, bg_next;
    logic                bold_reg, bold_next;
    logic                out_valid_reg, out_valid_next;
    asgr_pkg::byte_t     out_byte_reg, out_byte_next;
    asgr_pkg::attr_t     attr_reg, attr_next;

    logic                accept;
    logic                is_final;
    logic                is_param;
    logic                wr_en;
    asgr_pkg::code_t     wr_code;
    logic                rd_en;
    asgr_pkg::code_t     rd_code;
    asgr_pkg::code_t     unit_code;
    asgr_pkg::value_t    unit_sum;
    logic                unit_digit;
    logic                unit_apply;

    asgr_ram #(
        .WIDTH (4),
        .DEPTH (MAX_PARAM_CHARS)
    ) u_param_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_code),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_code)
    );

    assign in_ready = (seq_reg == SEQ_IDLE)
                   && (!out_valid_reg || out_ready || mode_reg != MODE_NORMAL
                       || in_byte == asgr_pkg::ESC_BYTE);
    assign accept   = in_valid && in_ready;
    assign is_final = in_byte inside {[asgr_pkg::FINAL_LO:asgr_pkg::FINAL_HI]};
    assign is_param = (in_byte inside {[asgr_pkg::CHAR_ZERO:asgr_pkg::CHAR_NINE]})
                   || in_byte == asgr_pkg::CHAR_SEMI;
    assign wr_code  = (in_byte == asgr_pkg::CHAR_SEMI) ? asgr_pkg::CODE_SEMI
                                                       : 4'(in_byte - asgr_pkg::CHAR_ZERO);
    assign wr_en    = accept && mode_reg == MODE_CSI && is_param
                   && count_reg < CW'(MAX_PARAM_CHARS);

    // shared multiply-by-ten and add unit
    assign unit_code  = (seq_reg == SEQ_EVAL) ? rd_code : asgr_pkg::CODE_SEMI;
    assign unit_digit = unit_code <= asgr_pkg::CODE_DIGIT_MAX;
    assign unit_sum   = (value_reg << 3) + (value_reg << 1)
                      + asgr_pkg::value_t'(unit_code);

    always_comb
    begin
        mode_next      = mode_reg;
        seq_next       = seq_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        bold_next      = bold_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        attr_next      = attr_reg;
        rd_en          = 1'b0;
        unit_apply     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_byte == asgr_pkg::ESC_BYTE)
                    begin
                        mode_next  = MODE_ESC;
                        count_next = '0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = in_byte;
                        attr_next      = asgr_pkg::make_attribute(fg_reg, bg_reg, bold_reg);
                    end
                end
                MODE_ESC:
                begin
                    if (in_byte == asgr_pkg::CHAR_LBRACKET)
                    begin
                        mode_next  = MODE_CSI;
                        count_next = '0;
                    end
                    else if (in_byte != asgr_pkg::ESC_BYTE)
                    begin
                        mode_next  = MODE_NORMAL;
                        count_next = '0;
                    end
                end
                MODE_DISCARD:
                begin
                    if (in_byte == asgr_pkg::ESC_BYTE)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (is_final)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_CSI:
                begin
                    if (in_byte == asgr_pkg::CHAR_M)
                    begin
                        mode_next  = MODE_NORMAL;
                        seq_next   = SEQ_FETCH;
                        idx_next   = '0;
                        value_next = '0;
                    end
                    else if (is_final)
                    begin
                        mode_next  = MODE_NORMAL;
                        count_next = '0;
                    end
                    else if (wr_en)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        mode_next = MODE_DISCARD;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end

        case (seq_reg)
            SEQ_FETCH:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    seq_next = SEQ_EVAL;
                end
                else
                begin
                    // implied trailing separator
                    unit_apply = 1'b1;
                    seq_next   = SEQ_IDLE;
                    count_next = '0;
                end
            end
            SEQ_EVAL:
            begin
                idx_next = idx_reg + CW'(1);
                seq_next = SEQ_FETCH;
                if (unit_digit)
                begin
                    if (value_reg > asgr_pkg::VALUE_LIMIT)
                    begin
                        seq_next   = SEQ_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        value_next = unit_sum;
                    end
                end
                else
                begin
                    unit_apply = 1'b1;
                    value_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (unit_apply)
        begin
            if (value_reg == asgr_pkg::SGR_RESET)
            begin
                fg_next   = asgr_pkg::FG_RESET;
                bg_next   = asgr_pkg::BG_RESET;
                bold_next = 1'b0;
            end
            else if (value_reg == asgr_pkg::SGR_BOLD)
            begin
                bold_next = 1'b1;
            end
            else if (value_reg inside {[asgr_pkg::SGR_FG_LO:asgr_pkg::SGR_FG_HI]})
            begin
                fg_next = 4'(value_reg - asgr_pkg::SGR_FG_LO);
            end
            else if (value_reg inside {[asgr_pkg::SGR_BRT_LO:asgr_pkg::SGR_BRT_HI]})
            begin
                fg_next = 4'(value_reg - asgr_pkg::BRT_OFFSET);
            end
            else if (value_reg inside {[asgr_pkg::SGR_BG_LO:asgr_pkg::SGR_BG_HI]})
            begin
                bg_next = 3'(value_reg - asgr_pkg::SGR_BG_LO);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            seq_reg       <= SEQ_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            value_reg     <= '0;
            fg_reg        <= asgr_pkg::FG_RESET;
            bg_reg        <= asgr_pkg::BG_RESET;
            bold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            seq_reg       <= seq_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            value_reg     <= value_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            bold_reg      <= bold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        attr_reg     <= attr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign attribute = attr_reg;

    // input is held off while the parameter walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> seq_reg == SEQ_IDLE)
        else $error("input taken during parameter walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != SEQ_IDLE |-> mode_reg == MODE_NORMAL)
        else $error("parameter walk outside normal mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PARAM_CHARS))
        else $error("parameter count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_EVAL |-> idx_reg < count_reg)
        else $error("evaluating past stored parameters");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_IDLE |=> seq_reg == SEQ_IDLE || seq_reg == SEQ_FETCH)
        else $error("walk started without a fetch");

endmodule
